@@ hdl/tmcg_pkg.sv @@
// ----------------------------------------------------------------------------
// tmcg_pkg
// Shared types, constants and tables of the torus mesh cell generator.
// ----------------------------------------------------------------------------
package tmcg_pkg;

    // largest segment count honored on either axis
    localparam int MAX_SEGMENTS = 256;

    // widths
    localparam int CNT_W  = 9;     // segment count registers
    localparam int IDX_W  = 8;     // grid indices
    localparam int PH_W   = 32;    // phase, fraction of a full turn
    localparam int COR_W  = 34;    // cordic datapath
    localparam int TRI_W  = 16;    // triangle indices
    localparam int CFG_IW = 3;     // configuration index

    // configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_TUBE_RADIUS   = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_RING_RADIUS   = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_RING_SEGMENTS = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_TUBE_SEGMENTS = 3'd3;

    // quadrant codes
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // 1/gain in Q2.30, start of x
    localparam logic signed [COR_W-1:0] CORDIC_X0 = 34'sd652032874;

    // one step of the phase divider
    typedef struct packed {
        logic [CNT_W-1:0] rem;
        logic [PH_W-1:0]  quo;
    } t_div;

    // one step of the cordic rotator
    typedef struct packed {
        logic signed [COR_W-1:0] x;
        logic signed [COR_W-1:0] y;
        logic signed [COR_W-1:0] z;
        logic [1:0]              quad;
    } t_cordic;

    // triangle vertex indices of one cell
    typedef struct packed {
        logic [TRI_W-1:0] cur;
        logic [TRI_W-1:0] nxt;
        logic [TRI_W-1:0] curn;
        logic [TRI_W-1:0] nxtn;
    } t_tri;

    // atan(2^-k) in units of 2^-32 turn
    function automatic logic signed [COR_W-1:0] tmcg_atan(input int k);
        logic signed [COR_W-1:0] v;
        case (k)
            0:  v = 34'sd536870912;
            1:  v = 34'sd316933406;
            2:  v = 34'sd167458907;
            3:  v = 34'sd85004756;
            4:  v = 34'sd42667331;
            5:  v = 34'sd21354465;
            6:  v = 34'sd10679838;
            7:  v = 34'sd5340245;
            8:  v = 34'sd2670163;
            9:  v = 34'sd1335087;
            10: v = 34'sd667544;
            11: v = 34'sd333772;
            12: v = 34'sd166886;
            13: v = 34'sd83443;
            14: v = 34'sd41722;
            15: v = 34'sd20861;
            16: v = 34'sd10430;
            17: v = 34'sd5215;
            18: v = 34'sd2608;
            19: v = 34'sd1304;
            20: v = 34'sd652;
            21: v = 34'sd326;
            22: v = 34'sd163;
            23: v = 34'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ hdl/tmcg_div_cell.sv @@
// ----------------------------------------------------------------------------
// tmcg_div_cell
// One restoring step of the phase divider: one quotient bit per cell.
// ----------------------------------------------------------------------------
module tmcg_div_cell
    import tmcg_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [CNT_W-1:0] i_divisor,
    input  t_div             i_d,
    output t_div             o_d
);

    logic [CNT_W:0] two_r;
    logic           ge;
    t_div           n_d;
    t_div           r_d;

    // shift, compare, subtract
    always_comb begin
        two_r     = {i_d.rem, 1'b0};
        ge        = two_r >= {1'b0, i_divisor};
        n_d.rem   = ge ? CNT_W'(two_r - {1'b0, i_divisor}) : CNT_W'(two_r);
        n_d.quo   = {i_d.quo[PH_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

@@ hdl/tmcg_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// tmcg_cordic_cell
// One rotation-mode cordic micro-rotation with a fixed shift.
// ----------------------------------------------------------------------------
module tmcg_cordic_cell
    import tmcg_pkg::*;
#(
    parameter int SHIFT = 0
) (
    input  logic    i_clk,
    input  logic    i_en,
    input  t_cordic i_d,
    output t_cordic o_d
);

    localparam logic signed [COR_W-1:0] ATAN = tmcg_atan(SHIFT);

    logic signed [COR_W-1:0] xs;
    logic signed [COR_W-1:0] ys;
    t_cordic                 n_d;
    t_cordic                 r_d;

    // rotate toward zero residual angle
    always_comb begin
        xs       = i_d.x >>> SHIFT;
        ys       = i_d.y >>> SHIFT;
        n_d.quad = i_d.quad;
        if (!i_d.z[COR_W-1]) begin
            n_d.x = i_d.x - ys;
            n_d.y = i_d.y + xs;
            n_d.z = i_d.z - ATAN;
        end else begin
            n_d.x = i_d.x + ys;
            n_d.y = i_d.y - xs;
            n_d.z = i_d.z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

@@ hdl/torus_mesh_cell_generator_unit.sv @@
// ----------------------------------------------------------------------------
// torus_mesh_cell_generator_unit
// Torus vertex, normal and quad triangle indices for one grid cell.
// ----------------------------------------------------------------------------
// Fully pipelined: one item is accepted every cycle while the output register
// is empty or being taken. Each item passes through the input register, then 32
// divider cells that form the phase one bit each, CORDIC_STAGES cordic cells,
// quadrant fix, two multiply stages and the output register. The whole pipe
// advances whenever the output register is empty or being taken, so a stalled
// result holds the pipe while bubbles stay in it. Configuration must only
// change while idle.
module torus_mesh_cell_generator_unit
    import tmcg_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CFG_IW-1:0]   i_cfg_idx,
    input  logic [15:0]         i_cfg_data,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [IDX_W-1:0]    i_ring_index,
    input  logic [IDX_W-1:0]    i_tube_index,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [17:0]  o_pos_x,
    output logic signed [17:0]  o_pos_y,
    output logic signed [17:0]  o_pos_z,
    output logic signed [15:0]  o_norm_x,
    output logic signed [15:0]  o_norm_y,
    output logic signed [15:0]  o_norm_z,
    output logic [TRI_W-1:0]    o_tri_a0,
    output logic [TRI_W-1:0]    o_tri_a1,
    output logic [TRI_W-1:0]    o_tri_a2,
    output logic [TRI_W-1:0]    o_tri_b0,
    output logic [TRI_W-1:0]    o_tri_b1,
    output logic [TRI_W-1:0]    o_tri_b2
);

    localparam int DIV_END = PH_W;
    localparam int COR_END = DIV_END + CORDIC_STAGES;
    localparam int Q_ST    = COR_END + 1;
    localparam int M1_ST   = COR_END + 2;
    localparam int M2_ST   = COR_END + 3;
    localparam int LAT     = COR_END + 4;

    // configuration registers
    logic [15:0]      r_tube_radius;
    logic [15:0]      r_ring_radius;
    logic [CNT_W-1:0] r_ring_segments;
    logic [CNT_W-1:0] r_tube_segments;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tube_radius   <= 16'd256;
            r_ring_radius   <= 16'd512;
            r_ring_segments <= CNT_W'(32);
            r_tube_segments <= CNT_W'(16);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TUBE_RADIUS:   r_tube_radius   <= i_cfg_data;
                CFG_RING_RADIUS:   r_ring_radius   <= i_cfg_data;
                CFG_RING_SEGMENTS: r_ring_segments <= i_cfg_data[CNT_W-1:0];
                CFG_TUBE_SEGMENTS: r_tube_segments <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // effective counts
    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] v;
        if (c == '0) begin
            v = CNT_W'(1);
        end else if (int'(c) > MAX_SEGMENTS) begin
            v = CNT_W'(MAX_SEGMENTS);
        end else begin
            v = c;
        end
        return v;
    endfunction

    logic [CNT_W-1:0] rn;
    logic [CNT_W-1:0] tn;
    assign rn = eff_count(r_ring_segments);
    assign tn = eff_count(r_tube_segments);

    // pipeline control
    logic           en;
    logic [LAT:0]   r_vld;

    assign en      = !r_vld[LAT] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-1:0], i_valid};
        end
    end

    // input register with index saturation
    logic [IDX_W-1:0] r_i;
    logic [IDX_W-1:0] r_j;
    logic [IDX_W-1:0] n_i;
    logic [IDX_W-1:0] n_j;

    always_comb begin
        n_i = ({1'b0, i_ring_index} >= rn) ? IDX_W'(rn - 1'b1) : i_ring_index;
        n_j = ({1'b0, i_tube_index} >= tn) ? IDX_W'(tn - 1'b1) : i_tube_index;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_i <= n_i;
            r_j <= n_j;
        end
    end

    // triangle indices, then a delay line to the output
    t_tri             r_tri [1:LAT];
    t_tri             n_tri;
    logic [CNT_W-1:0] i1;
    logic [CNT_W-1:0] j1;

    always_comb begin
        i1 = ({1'b0, r_i} + 1'b1 == rn) ? '0 : {1'b0, r_i} + 1'b1;
        j1 = ({1'b0, r_j} + 1'b1 == tn) ? '0 : {1'b0, r_j} + 1'b1;
        n_tri.cur  = TRI_W'(r_i) * TRI_W'(tn) + TRI_W'(r_j);
        n_tri.nxt  = TRI_W'(i1) * TRI_W'(tn) + TRI_W'(r_j);
        n_tri.curn = TRI_W'(r_i) * TRI_W'(tn) + TRI_W'(j1);
        n_tri.nxtn = TRI_W'(i1) * TRI_W'(tn) + TRI_W'(j1);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tri[1] <= n_tri;
            for (int k = 2; k <= LAT; k++) begin
                r_tri[k] <= r_tri[k-1];
            end
        end
    end

    // phase dividers: floor(index * 2^32 / count)
    t_div w_rdiv [0:DIV_END];
    t_div w_tdiv [0:DIV_END];

    assign w_rdiv[0] = '{rem: {1'b0, r_i}, quo: '0};
    assign w_tdiv[0] = '{rem: {1'b0, r_j}, quo: '0};

    for (genvar g = 0; g < DIV_END; g++) begin : g_div
        tmcg_div_cell u_rdiv (
            .i_clk    (i_clk),
            .i_en     (en),
            .i_divisor(rn),
            .i_d      (w_rdiv[g]),
            .o_d      (w_rdiv[g+1])
        );
        tmcg_div_cell u_tdiv (
            .i_clk    (i_clk),
            .i_en     (en),
            .i_divisor(tn),
            .i_d      (w_tdiv[g]),
            .o_d      (w_tdiv[g+1])
        );
    end

    // cordic chains
    t_cordic w_rcor [0:CORDIC_STAGES];
    t_cordic w_tcor [0:CORDIC_STAGES];

    assign w_rcor[0] = '{x: CORDIC_X0, y: '0,
                         z: COR_W'(w_rdiv[DIV_END].quo[PH_W-3:0]),
                         quad: w_rdiv[DIV_END].quo[PH_W-1:PH_W-2]};
    assign w_tcor[0] = '{x: CORDIC_X0, y: '0,
                         z: COR_W'(w_tdiv[DIV_END].quo[PH_W-3:0]),
                         quad: w_tdiv[DIV_END].quo[PH_W-1:PH_W-2]};

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cor
        tmcg_cordic_cell #(.SHIFT(g)) u_rcor (
            .i_clk(i_clk),
            .i_en (en),
            .i_d  (w_rcor[g]),
            .o_d  (w_rcor[g+1])
        );
        tmcg_cordic_cell #(.SHIFT(g)) u_tcor (
            .i_clk(i_clk),
            .i_en (en),
            .i_d  (w_tcor[g]),
            .o_d  (w_tcor[g+1])
        );
    end

    // round Q2.30 to Q1.14 and clamp to one
    function automatic logic signed [15:0] round_q14(input logic signed [COR_W-1:0] v);
        logic signed [COR_W:0] t;
        logic signed [15:0]    r;
        t = (COR_W+1)'(v) + 35'sd32768;
        t = t >>> 16;
        if (t > 35'sd16384) begin
            r = 16'sd16384;
        end else if (t < -35'sd16384) begin
            r = -16'sd16384;
        end else begin
            r = $signed(t[15:0]);
        end
        return r;
    endfunction

    // quadrant fix: cos and sin of one chain
    function automatic logic signed [2*16-1:0] quad_fix(input t_cordic d);
        logic signed [COR_W-1:0] cv;
        logic signed [COR_W-1:0] sv;
        case (d.quad)
            QUAD_0: begin cv = d.x;  sv = d.y;  end
            QUAD_1: begin cv = -d.y; sv = d.x;  end
            QUAD_2: begin cv = -d.x; sv = -d.y; end
            default: begin cv = d.y; sv = -d.x; end
        endcase
        return {round_q14(cv), round_q14(sv)};
    endfunction

    logic signed [15:0] r_ct, r_st, r_cp, r_sp;

    always_ff @(posedge i_clk) begin
        if (en) begin
            {r_ct, r_st} <= quad_fix(w_rcor[CORDIC_STAGES]);
            {r_cp, r_sp} <= quad_fix(w_tcor[CORDIC_STAGES]);
        end
    end

    // first multiply stage
    logic signed [33:0] r_a;
    logic signed [31:0] r_ncx, r_ncy;
    logic signed [32:0] r_pzp;
    logic signed [15:0] r_ct2, r_st2, r_sp2;
    logic signed [32:0] tube_cp;

    assign tube_cp = $signed({1'b0, r_tube_radius}) * r_cp;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a   <= $signed({4'b0, r_ring_radius, 14'b0}) + 34'(tube_cp);
            r_ncx <= r_cp * r_ct;
            r_ncy <= r_cp * r_st;
            r_pzp <= $signed({1'b0, r_tube_radius}) * r_sp;
            r_ct2 <= r_ct;
            r_st2 <= r_st;
            r_sp2 <= r_sp;
        end
    end

    // second multiply stage, finish z and normals
    logic signed [49:0] r_pxp, r_pyp;
    logic signed [17:0] r_pz;
    logic signed [15:0] r_nx, r_ny, r_nz;
    logic signed [33:0] n_pz_t;
    logic signed [32:0] n_nx_t, n_ny_t;

    always_comb begin
        n_pz_t = (34'(r_pzp) + 34'sd8192) >>> 14;
        n_nx_t = (33'(r_ncx) + 33'sd8192) >>> 14;
        n_ny_t = (33'(r_ncy) + 33'sd8192) >>> 14;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pxp <= r_a * r_ct2;
            r_pyp <= r_a * r_st2;
            if (n_pz_t > 34'sd131071) begin
                r_pz <= 18'sd131071;
            end else if (n_pz_t < -34'sd131072) begin
                r_pz <= -18'sd131072;
            end else begin
                r_pz <= $signed(n_pz_t[17:0]);
            end
            r_nx <= $signed(n_nx_t[15:0]);
            r_ny <= $signed(n_ny_t[15:0]);
            r_nz <= r_sp2;
        end
    end

    // output register: round and saturate x and y
    function automatic logic signed [17:0] pos_round(input logic signed [49:0] p);
        logic signed [50:0] t;
        logic signed [17:0] r;
        t = (51'(p) + 51'sd134217728) >>> 28;
        if (t > 51'sd131071) begin
            r = 18'sd131071;
        end else if (t < -51'sd131072) begin
            r = -18'sd131072;
        end else begin
            r = $signed(t[17:0]);
        end
        return r;
    endfunction

    logic signed [17:0] r_ox, r_oy, r_oz;
    logic signed [15:0] r_onx, r_ony, r_onz;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ox  <= pos_round(r_pxp);
            r_oy  <= pos_round(r_pyp);
            r_oz  <= r_pz;
            r_onx <= r_nx;
            r_ony <= r_ny;
            r_onz <= r_nz;
        end
    end

    assign o_pos_x  = r_ox;
    assign o_pos_y  = r_oy;
    assign o_pos_z  = r_oz;
    assign o_norm_x = r_onx;
    assign o_norm_y = r_ony;
    assign o_norm_z = r_onz;
    assign o_tri_a0 = r_tri[LAT].cur;
    assign o_tri_a1 = r_tri[LAT].nxt;
    assign o_tri_a2 = r_tri[LAT].curn;
    assign o_tri_b0 = r_tri[LAT].nxt;
    assign o_tri_b1 = r_tri[LAT].nxtn;
    assign o_tri_b2 = r_tri[LAT].curn;

`ifndef NO_ASSERTIONS
    // an accepted item enters the first stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_vld[0])
        else $error("accepted item lost at input register");

    // the quadrant stage only produces unit-range values
    a_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[Q_ST] |-> (r_sp <= 16'sd16384 && r_sp >= -16'sd16384))
        else $error("sine out of unit range");

    // a stalled result stays in the output register
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(r_tri[LAT])))
        else $error("stalled result changed");

    // the multiply stages see valid items in order
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_vld[M1_ST]) |=> r_vld[M2_ST])
        else $error("item dropped between multiply stages");
`endif

endmodule
